@@ hw/rtl/plec_pkg.sv @@
// plec_pkg: shared types and constants of the piecewise-linear curve evaluator
// holds the sequencer state type, register indexes and divider interface structs
// no dependencies
`default_nettype none

package plec_pkg;

   // breakpoint table depth and index width
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);

   // fraction width of the interpolation weight
   localparam int FRAC_W     = 16;
   localparam int DIV_STEPS  = FRAC_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   // configuration register indexes
   localparam logic [1:0] CSR_MIN_X       = 2'd0;
   localparam logic [1:0] CSR_MAX_X       = 2'd1;
   localparam logic [1:0] CSR_POINT_COUNT = 2'd2;

   // request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_FINISH
   } plec_state_type;

   typedef struct packed {
      logic              start;
      logic [FRAC_W-1:0] num;
      logic [FRAC_W-1:0] den;
   } plec_div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } plec_div_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/piecewise_linear_curve_eval_core.sv @@
// piecewise_linear_curve_eval_core: breakpoint table with linear interpolation
// top level; depends on plec_pkg and plec_div
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  command, point_index, point_x, point_y, query_x
//   rsp      out        rsp_valid / rsp_ready  value_y, x_outside
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a write request gives no response
// an evaluate request goes straight to finish when flagged; otherwise it scans and either
// returns a point's own y or interpolates
// interpolation adds a divide, a multiply and an add; response valid after finish
// reset is synchronous and clears control state and the csr registers, not the table
// a stalled response waits in the output register while the next request runs
// finish holds only while that register is still full
`default_nettype none

module piecewise_linear_curve_eval_core
   import plec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [3:0]         req_point_index,
   input  wire logic signed [15:0] req_point_x,
   input  wire logic signed [15:0] req_point_y,
   input  wire logic signed [15:0] req_query_x,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_value_y,
   output logic                    rsp_x_outside,
   // configuration channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   // configuration registers
   logic signed [15:0] min_x_ff;
   logic signed [15:0] max_x_ff;
   logic [4:0]         point_count_ff;

   // breakpoint table
   logic signed [15:0] bx_mem [MAX_POINTS];
   logic signed [15:0] by_mem [MAX_POINTS];
   logic signed [15:0] rdx_ff;
   logic signed [15:0] rdy_ff;

   // sequencer
   plec_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic signed [15:0] q_ff, q_in;
   logic signed [15:0] px_ff, px_in;
   logic signed [15:0] py_ff, py_in;
   logic signed [16:0] dy_ff, dy_in;
   logic signed [33:0] prod_ff, prod_in;
   logic signed [15:0] res_y_ff, res_y_in;
   logic               res_flag_ff, res_flag_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic               rsp_flag_ff, rsp_flag_in;

   // divider
   plec_div_req_type   div_req;
   plec_div_rsp_type   div_rsp;

   logic               req_acc;
   logic               eval_acc;
   logic               write_acc;
   logic               outside;
   logic               hit;
   logic               own_y;
   logic               at_last;
   logic               rsp_free;
   logic signed [16:0] num_w;
   logic signed [16:0] den_w;
   logic signed [33:0] sum_w;
   logic [IDX_W-1:0]   last_w;

   assign req_acc   = req_valid & req_ready;
   assign eval_acc  = req_acc & (req_command == CMD_EVAL);
   assign write_acc = req_acc & (req_command == CMD_WRITE);
   assign outside   = (req_query_x < min_x_ff) | (req_query_x > max_x_ff);

   // breakpoint found when its x reaches the query
   assign hit       = rdx_ff >= q_ff;
   // first point, repeated x or exact hit give the point's own y
   assign own_y     = (idx_ff == '0) | (rdx_ff == px_ff) | (rdx_ff == q_ff);
   assign at_last   = idx_ff == last_ff;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign num_w     = 17'(q_ff) - 17'(px_ff);
   assign den_w     = 17'(rdx_ff) - 17'(px_ff);
   assign sum_w     = prod_ff + 34'sd32768;

   // clamp point_count into 1..MAX_POINTS and keep the last index
   always_comb begin
      if (point_count_ff == 5'd0) begin
         last_w = '0;
      end else if (32'(point_count_ff) > MAX_POINTS) begin
         last_w = IDX_W'(MAX_POINTS - 1);
      end else begin
         last_w = IDX_W'(point_count_ff - 5'd1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_acc) begin
               state_in = outside ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = own_y ? ST_FINISH : ST_DIV;
            end else if (at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      idx_in       = idx_ff;
      last_in      = last_ff;
      q_in         = q_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      res_y_in     = res_y_ff;
      res_flag_in  = res_flag_ff;
      div_req      = '0;
      div_req.num  = num_w[15:0];
      div_req.den  = den_w[15:0];
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_y_in     = rsp_y_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (eval_acc) begin
               idx_in      = '0;
               last_in     = last_w;
               q_in        = req_query_x;
               res_flag_in = outside;
               res_y_in    = '0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_y_in = rdy_ff;
               if (!own_y) begin
                  // interpolate between previous point and this one
                  div_req.start = 1'b1;
                  dy_in         = 17'(rdy_ff) - 17'(py_ff);
               end
            end else begin
               px_in    = rdx_ff;
               py_in    = rdy_ff;
               res_y_in = rdy_ff;
               if (!at_last) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_DIV: begin
         end
         ST_MUL: begin
            prod_in = 34'(dy_ff) * 34'($signed({1'b0, div_rsp.quot}));
         end
         ST_ADD: begin
            // round half up, then add to y0
            res_y_in = py_ff + sum_w[31:16];
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_y_in     = res_y_ff;
               rsp_flag_in  = res_flag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff       <= 16'sd0;
         max_x_ff       <= 16'sd256;
         point_count_ff <= 5'd1;
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            CSR_MIN_X:       min_x_ff       <= csr_wdata;
            CSR_MAX_X:       max_x_ff       <= csr_wdata;
            CSR_POINT_COUNT: point_count_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // table write and registered read at the next scan index
   always_ff @(posedge clock) begin
      if (write_acc && (32'(req_point_index) < MAX_POINTS)) begin
         bx_mem[IDX_W'(req_point_index)] <= req_point_x;
         by_mem[IDX_W'(req_point_index)] <= req_point_y;
      end
      rdx_ff <= bx_mem[idx_in];
      rdy_ff <= by_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      last_ff     <= last_in;
      q_ff        <= q_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      res_y_ff    <= res_y_in;
      res_flag_ff <= res_flag_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   plec_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_y   = rsp_y_ff;
   assign rsp_x_outside = rsp_flag_ff;

   // divider only finishes while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider done outside divide phase");

   // a flagged response carries zero
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_x_outside |-> rsp_value_y == 16'sd0)
      else $error("flagged response with nonzero value");

   // scan never runs past the last breakpoint in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= last_ff)
      else $error("scan index past last breakpoint");

   // a new response is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_y))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/plec_div.sv @@
// plec_div: restoring divider giving the fraction floor((num << 16) / den)
// one quotient bit per cycle, expects num < den; depends on plec_pkg
`default_nettype none

module plec_div
   import plec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire plec_div_req_type div_req,
   output plec_div_rsp_type      div_rsp
);

   logic [FRAC_W-1:0]    rem_ff, rem_in;
   logic [FRAC_W-1:0]    den_ff, den_in;
   logic [FRAC_W-1:0]    quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FRAC_W:0]      shifted;
   logic [FRAC_W:0]      diff;
   logic                 ge;

   assign shifted = {rem_ff, 1'b0};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quot_in = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per step
         rem_in  = ge ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
         quot_in = {quot_ff[FRAC_W-2:0], ge};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

`default_nettype wire

@@ tb/tb_piecewise_linear_curve_eval_core.sv @@
// tb_piecewise_linear_curve_eval_core: self-checking bench for the curve evaluator core
// directed table then random phases, checked against fixed results or a built-in interpolation predictor
// depends on plec_pkg and piecewise_linear_curve_eval_core
`default_nettype none

module tb_piecewise_linear_curve_eval_core
   import plec_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int NUM_PHASES      = 12;
   localparam int EVALS_PER_PHASE = 110;

   // register index the block has no register for
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                command;
      logic [3:0]          point_index;
      logic signed [15:0]  point_x;
      logic signed [15:0]  point_y;
      logic signed [15:0]  query_x;
   } curve_request_type;

   typedef struct packed {
      logic signed [15:0]  value_y;
      logic                x_outside;
   } curve_result_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [1:0]          csr_index;
      logic [15:0]         csr_data;
      curve_request_type   request;
      logic                fixed;
      curve_result_type    fixed_result;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_command;
   logic [3:0]          req_point_index;
   logic signed [15:0]  req_point_x;
   logic signed [15:0]  req_point_y;
   logic signed [15:0]  req_query_x;
   logic                rsp_valid;
   logic                rsp_ready;
   logic signed [15:0]  rsp_value_y;
   logic                rsp_x_outside;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [15:0]         csr_wdata;

   // shadow of the breakpoint table and csr registers, updated at acceptance
   logic signed [15:0]  shadow_x [MAX_POINTS];
   logic signed [15:0]  shadow_y [MAX_POINTS];
   logic signed [15:0]  dom_min;
   logic signed [15:0]  dom_max;
   logic [4:0]          points_used;

   // y values still owed by the block, oldest first
   curve_result_type    pending_curve_values [$];
   curve_result_type    oldest;

   // directed stimulus rows
   directed_row_type    stim_rows [$];

   int                  failures = 0;
   int                  cycle_count = 0;
   bit                  quiet_run = 1'b0;

   piecewise_linear_curve_eval_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_query_x     (req_query_x),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_y     (rsp_value_y),
      .rsp_x_outside   (rsp_x_outside),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // append a directed row
   function automatic void add_row(directed_row_type row);
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   // book a result the block now owes
   function automatic void owe_result(curve_result_type r);
      pending_curve_values.insert(pending_curve_values.size(), r);
   endfunction

   // interpolated y at query x from the shadow table and domain
   function automatic curve_result_type interpolate_at(logic signed [15:0] q);
      curve_result_type   r;
      int                 n;
      int                 i;
      int                 y;
      bit                 found;
      logic signed [15:0] px;
      logic signed [15:0] py;
      longint             num;
      longint             den;
      longint             frac;
      longint             prod;
      r.value_y   = '0;
      r.x_outside = 1'b0;
      // outside the domain, including an inverted one
      if (q < dom_min || q > dom_max) begin
         r.x_outside = 1'b1;
         return r;
      end
      // count of zero acts as one, counts past the table clamp to its depth
      n = (points_used == 0) ? 1 : (points_used > MAX_POINTS ? MAX_POINTS : points_used);
      px    = shadow_x[0];
      py    = shadow_y[0];
      y     = py;
      found = 1'b0;
      for (i = 0; i < n && !found; i++) begin
         if (shadow_x[i] >= q) begin
            found = 1'b1;
            // first point, repeated x or exact hit all give the point's own y
            if (shadow_x[i] == px || shadow_x[i] == q) begin
               y = shadow_y[i];
            end else begin
               // here px < q < x1, so the weight fits in 16 unsigned bits
               num  = longint'(q) - longint'(px);
               den  = longint'(shadow_x[i]) - longint'(px);
               frac = (num <<< 16) / den;
               prod = (longint'(shadow_y[i]) - longint'(py)) * frac + 32768;
               y    = int'(py) + int'(prod >>> 16);
            end
         end else begin
            px = shadow_x[i];
            py = shadow_y[i];
            y  = py;
         end
      end
      // past the last point in use the last y carries through
      r.value_y = y[15:0];
      return r;
   endfunction

   function automatic directed_row_type write_row(logic [3:0] idx, logic [15:0] px,
                                                  logic [15:0] py);
      directed_row_type row;
      row = '0;
      row.kind                = ROW_REQUEST;
      row.request.command     = CMD_WRITE;
      row.request.point_index = idx;
      row.request.point_x     = px;
      row.request.point_y     = py;
      return row;
   endfunction

   function automatic directed_row_type eval_row(logic [15:0] q, logic fixed,
                                                 logic [15:0] ey, logic eo);
      directed_row_type row;
      row = '0;
      row.kind                   = ROW_REQUEST;
      row.request.command        = CMD_EVAL;
      row.request.query_x        = q;
      row.fixed                  = fixed;
      row.fixed_result.value_y   = ey;
      row.fixed_result.x_outside = eo;
      return row;
   endfunction

   function automatic directed_row_type csr_row(logic [1:0] index, logic [15:0] data);
      directed_row_type row;
      row = '0;
      row.kind      = ROW_CSR;
      row.csr_index = index;
      row.csr_data  = data;
      return row;
   endfunction

   // present one request, with an optional leading gap, and book its outcome
   task automatic send_request(input curve_request_type rq, input logic fixed,
                               input curve_result_type fixed_result);
      int gap;
      gap = (!quiet_run && $urandom_range(3, 0) == 0) ? $urandom_range(14, 1) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= rq.command;
      req_point_index <= rq.point_index;
      req_point_x     <= rq.point_x;
      req_point_y     <= rq.point_y;
      req_query_x     <= rq.query_x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted: writes update the shadow, evaluations owe one result
      if (rq.command == CMD_WRITE) begin
         shadow_x[rq.point_index] = rq.point_x;
         shadow_y[rq.point_index] = rq.point_y;
      end else begin
         owe_result(fixed ? fixed_result : interpolate_at(rq.query_x));
      end
   endtask

   // csr write, mirrored into the predictor once the block takes it
   task automatic write_csr(input logic [1:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MIN_X:       dom_min = data;
         CSR_MAX_X:       dom_max = data;
         CSR_POINT_COUNT: points_used = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every owed result, then let a trailing write finish
   task automatic drain_curve_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_curve_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random stall bursts, none in the quiet tail
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet_run && $urandom_range(19, 0) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(14, 1) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare every accepted response with the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_curve_values.size() == 0) begin
            $error("unexpected response: value_y %0d x_outside %0b",
                   rsp_value_y, rsp_x_outside);
            failures++;
         end else begin
            oldest = pending_curve_values.pop_front();
            if (rsp_value_y !== oldest.value_y) begin
               $error("value_y mismatch: expected %0d, actual %0d",
                      oldest.value_y, rsp_value_y);
               failures++;
            end
            if (rsp_x_outside !== oldest.x_outside) begin
               $error("x_outside mismatch: expected %0b, actual %0b",
                      oldest.x_outside, rsp_x_outside);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results outstanding",
                cycle_count, pending_curve_values.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      curve_request_type  rq;
      logic signed [15:0] a_val;
      logic signed [15:0] b_val;
      logic signed [15:0] new_min;
      logic signed [15:0] new_max;
      logic [15:0]        count_word;
      int                 cnt;
      int                 phase;
      int                 slot;
      int                 run_x;
      int                 lo;
      int                 hi;
      int                 roll;
      bit                 tight;

      // every input known from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_WRITE;
      req_point_index = '0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_query_x     = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MIN_X;
      csr_wdata       = '0;
      dom_min         = 16'sd0;
      dom_max         = 16'sd256;
      points_used     = 5'd1;
      foreach (shadow_x[i]) begin
         shadow_x[i] = '0;
         shadow_y[i] = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; fixed results only where they follow at a glance
      // reset domain is [0, 256] with one point in use
      add_row(eval_row(-1, 1'b1, 0, 1'b1));          // just below domain
      add_row(eval_row(257, 1'b1, 0, 1'b1));         // just above domain
      add_row(write_row(0, 0, 100));
      add_row(eval_row(0, 1'b1, 100, 1'b0));         // hit on the only point
      add_row(eval_row(256, 1'b1, 100, 1'b0));       // past the last point
      // widest domain, full table depth in use
      add_row(csr_row(CSR_MIN_X, 16'h8000));
      add_row(csr_row(CSR_MAX_X, 16'h7FFF));
      add_row(csr_row(CSR_POINT_COUNT, 16'd16));
      add_row(write_row(0, -32768, 32767));
      add_row(write_row(1, 0, -32768));
      add_row(write_row(2, 32767, 32767));
      add_row(write_row(15, 32767, -32768));         // top slot, never reached
      add_row(eval_row(-32768, 1'b1, 32767, 1'b0));  // first point scanned
      add_row(eval_row(32767, 1'b1, 32767, 1'b0));   // exact hit at the top
      add_row(eval_row(0, 1'b1, -32768, 1'b0));      // exact hit mid table
      add_row(eval_row(-1, 1'b0, 0, 1'b0));          // full-swing descending segment
      add_row(eval_row(1, 1'b0, 0, 1'b0));           // full-swing rising segment
      // unsorted table: first two points out of order
      add_row(write_row(0, 500, 1000));
      add_row(write_row(1, -500, -2000));
      add_row(eval_row(0, 1'b1, 1000, 1'b0));        // first point already above
      add_row(eval_row(600, 1'b0, 0, 1'b0));         // scan skips past both
      // count of zero behaves as one point
      add_row(csr_row(CSR_POINT_COUNT, 16'd0));
      add_row(eval_row(1000, 1'b1, 1000, 1'b0));
      // count above depth behaves as full depth
      add_row(csr_row(CSR_POINT_COUNT, 16'd31));
      add_row(eval_row(600, 1'b0, 0, 1'b0));
      // unused register index must change nothing
      add_row(csr_row(CSR_UNUSED, 16'hFFFF));
      add_row(eval_row(-32768, 1'b1, 1000, 1'b0));
      // inverted domain flags everything
      add_row(csr_row(CSR_MIN_X, 16'd100));
      add_row(csr_row(CSR_MAX_X, 16'hFF9C));
      add_row(eval_row(0, 1'b1, 0, 1'b1));
      // single-value domain
      add_row(csr_row(CSR_MIN_X, 16'd0));
      add_row(csr_row(CSR_MAX_X, 16'd0));
      add_row(eval_row(0, 1'b1, 1000, 1'b0));
      add_row(eval_row(1, 1'b1, 0, 1'b1));

      foreach (stim_rows[k]) begin
         if (stim_rows[k].kind == ROW_CSR) begin
            drain_curve_results();
            write_csr(stim_rows[k].csr_index, stim_rows[k].csr_data);
         end else begin
            send_request(stim_rows[k].request, stim_rows[k].fixed,
                         stim_rows[k].fixed_result);
         end
      end

      // random phases: new settings, a fresh sorted table, then mostly queries
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_curve_results();
         quiet_run = (phase >= NUM_PHASES - 2);

         a_val = 16'($urandom());
         b_val = 16'($urandom());
         case (phase % 5)
            0: begin
               // widest domain, every slot in use
               new_min = 16'sh8000;
               new_max = 16'sh7FFF;
               cnt     = MAX_POINTS;
            end
            1: begin
               new_min = (a_val < b_val) ? a_val : b_val;
               new_max = (a_val < b_val) ? b_val : a_val;
               cnt     = $urandom_range(MAX_POINTS, 1);
            end
            2: begin
               // counts outside 1..16
               new_min = (a_val < b_val) ? a_val : b_val;
               new_max = (a_val < b_val) ? b_val : a_val;
               cnt     = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(31, 17);
            end
            3: begin
               // inverted domain
               new_min = (a_val > b_val) ? a_val : b_val;
               new_max = (a_val > b_val) ? b_val : a_val;
               if (new_min == new_max) begin
                  new_min = 16'sh7FFF;
                  new_max = 16'sh8000;
               end
               cnt     = $urandom_range(MAX_POINTS, 1);
            end
            default: begin
               // domain of one value
               new_min = a_val;
               new_max = a_val;
               cnt     = MAX_POINTS;
            end
         endcase
         // upper bits of the count word carry junk
         count_word = 16'($urandom());
         count_word[4:0] = cnt[4:0];
         write_csr(CSR_MIN_X, new_min);
         write_csr(CSR_MAX_X, new_max);
         write_csr(CSR_POINT_COUNT, count_word);
         if ($urandom_range(2, 0) == 0) write_csr(CSR_UNUSED, 16'($urandom()));

         // sorted table, sometimes tightly spaced with repeated x
         run_x = -32768 + $urandom_range(30000, 0);
         tight = ($urandom_range(3, 0) == 0);
         for (slot = 0; slot < MAX_POINTS; slot++) begin
            run_x += tight ? $urandom_range(3, 0) : $urandom_range(4500, 0);
            if (run_x > 32767) run_x = 32767;
            rq.command     = CMD_WRITE;
            rq.point_index = slot[3:0];
            rq.point_x     = run_x[15:0];
            rq.point_y     = 16'($urandom());
            rq.query_x     = 16'($urandom());
            send_request(rq, 1'b0, '0);
         end

         repeat (EVALS_PER_PHASE) begin
            // unused fields carry junk
            rq.point_index = 4'($urandom());
            rq.point_x     = 16'($urandom());
            rq.point_y     = 16'($urandom());
            // a few stray writes scramble the table order
            rq.command     = ($urandom_range(99, 0) < 8) ? CMD_WRITE : CMD_EVAL;
            lo   = dom_min;
            hi   = dom_max;
            roll = $urandom_range(99, 0);
            if (roll < 55 && lo <= hi)
               rq.query_x = 16'(lo + $urandom_range(hi - lo, 0));
            else if (roll < 75)
               rq.query_x = 16'(shadow_x[$urandom_range(MAX_POINTS - 1, 0)]
                                + $urandom_range(2, 0) - 1);
            else if (roll < 85)
               rq.query_x = roll[0] ? dom_min : dom_max;
            else
               rq.query_x = 16'($urandom());
            send_request(rq, 1'b0, '0);
         end
      end

      drain_curve_results();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
